>>> rtl/pswc_pkg.sv
// package: types, constants and sequence helpers for the packet sequence window check
package pswc_pkg;

  localparam int SEQ_MODULO = 8;
  localparam int SEQ_W      = 4;
  localparam int WIDE_W     = SEQ_W + 1;
  localparam int CNT_W      = 4;
  localparam int WIN_W      = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;
  localparam int IN_DATA_W  = 40;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 24;

  localparam logic [CNT_W-1:0]  CNT_MAX  = 4'h0F;
  localparam logic [WIDE_W-1:0] WIDE_MOD = WIDE_W'(SEQ_MODULO);

  localparam logic [CFG_IDX_W-1:0] CFG_DATA_WINDOW = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DTE_MODE    = 1'd1;

  localparam logic [WIN_W-1:0] DATA_WINDOW_RST = 4'd2;

  typedef enum logic [2:0] {
    PS_IN_SEQ    = 3'd0,
    PS_DUPLICATE = 3'd1,
    PS_GAP       = 3'd2,
    PS_OUT_WIN   = 3'd3,
    PS_UNCHECKED = 3'd4
  } ps_status_t;

  typedef enum logic [1:0] {
    REPLY_NONE = 2'd0,
    REPLY_RR   = 2'd1,
    REPLY_REJ  = 2'd2
  } reply_kind_t;

  typedef enum logic [1:0] {
    RST_NONE  = 2'd0,
    RST_BAD_PS = 2'd1,
    RST_BAD_PR = 2'd2
  } reset_code_t;

  typedef struct packed {
    logic [SEQ_W-1:0] received_ps;
    logic [SEQ_W-1:0] received_pr;
    logic             is_data;
    logic             is_reset_request;
    logic [SEQ_W-1:0] recv_low;
    logic [SEQ_W-1:0] recv_high;
    logic [SEQ_W-1:0] send_low;
    logic [SEQ_W-1:0] send_next;
    logic             send_timed_out;
    logic             retransmitting;
    logic [SEQ_W-1:0] rejected_seq;
    logic [CNT_W-1:0] early_reply_count;
  } pswc_item_t;

  typedef struct packed {
    ps_status_t       ps_status;
    reply_kind_t      reply_kind;
    logic             restart_reply_timer;
    logic             release_valid;
    logic [SEQ_W-1:0] release_upto;
    logic             send_resume;
    logic             clear_timeout;
    logic             clear_retransmit;
    reset_code_t      reset_code;
    logic             reset_origin;
  } pswc_result_t;

  typedef struct packed {
    logic [SEQ_W-1:0] expected_seq;
    logic [CNT_W-1:0] data_count;
    logic             reject_outstanding;
  } pswc_state_t;

  typedef struct packed {
    logic [WIN_W-1:0] data_window;
    logic             dte_mode;
  } pswc_cfg_t;

  typedef struct packed {
    logic              hit;
    logic [WIDE_W-1:0] to_top;
  } win_pos_t;

  // position of mid within [low, high] with wrap, distance to the top
  function automatic win_pos_t window_pos(logic [SEQ_W-1:0] low, logic [SEQ_W-1:0] mid,
                                          logic [SEQ_W-1:0] high);
    logic [WIDE_W-1:0] l;
    logic [WIDE_W-1:0] m;
    logic [WIDE_W-1:0] h;
    win_pos_t          r;
    l = {1'b0, low};
    m = {1'b0, mid};
    h = {1'b0, high};
    if (h < l) begin
      if (m < l) begin
        m = m + WIDE_MOD;
      end
      h = h + WIDE_MOD;
    end
    r.hit    = (l <= m) && (m <= h);
    r.to_top = h - m;
    return r;
  endfunction

  // (v + 1) mod SEQ_MODULO for any 4-bit v
  function automatic logic [SEQ_W-1:0] seq_inc(logic [SEQ_W-1:0] v);
    logic [WIDE_W-1:0] s;
    s = {1'b0, v} + WIDE_W'(1);
    if (s >= WIDE_MOD) begin
      s = s - WIDE_MOD;
    end
    if (s >= WIDE_MOD) begin
      s = s - WIDE_MOD;
    end
    return s[SEQ_W-1:0];
  endfunction

endpackage

>>> rtl/packet_seq_window_check_unit.sv
// top level: packet sequence window check with stream ports and config port
// path: an accepted item passes the input register, then the result register that drives out_tvalid
// throughput: one item per cycle while out_tready is high; the channel state updates as an item
// enters the result register; the check logic between the two registers sets the cycle time
// reset: synchronous active-low rst_n clears both stages, the channel state and the registers
// to their defaults (data_window 2, dte_mode 1)
module packet_seq_window_check_unit
  import pswc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // ps[3:0] pr[7:4] recv_low[11:8] recv_high[15:12] send_low[19:16] send_next[23:20]
  // send_timed_out[24] retransmitting[25] rejected_seq[29:26] early_reply_count[33:30]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // is_data[0] is_reset_request[1]
  input  logic [IN_USER_W-1:0]  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // ps_status[2:0] reply_kind[4:3] restart_reply_timer[5] release_valid[6]
  // release_upto[10:7] send_resume[11] clear_timeout[12] clear_retransmit[13]
  // reset_code[15:14] reset_origin[16]
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  pswc_item_t   item_r;
  logic         item_valid_r;
  pswc_result_t res_r;
  logic         res_valid_r;
  pswc_state_t  st_r;
  pswc_state_t  st_nxt;
  pswc_cfg_t    cfg_r;
  pswc_result_t chk_res;
  pswc_item_t   in_item;
  logic         res_load;
  logic         in_fire;

  assign res_load  = item_valid_r && (!res_valid_r || out_tready);
  assign in_tready = !item_valid_r || res_load;
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  always_comb begin
    in_item.received_ps       = in_tdata[3:0];
    in_item.received_pr       = in_tdata[7:4];
    in_item.recv_low          = in_tdata[11:8];
    in_item.recv_high         = in_tdata[15:12];
    in_item.send_low          = in_tdata[19:16];
    in_item.send_next         = in_tdata[23:20];
    in_item.send_timed_out    = in_tdata[24];
    in_item.retransmitting    = in_tdata[25];
    in_item.rejected_seq      = in_tdata[29:26];
    in_item.early_reply_count = in_tdata[33:30];
    in_item.is_data           = in_tuser[0];
    in_item.is_reset_request  = in_tuser[1];
  end

  pswc_check u_check (
    .item (item_r),
    .cur  (st_r),
    .cfg  (cfg_r),
    .res  (chk_res),
    .nxt  (st_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      res_valid_r  <= 1'b0;
      st_r         <= '0;
      cfg_r.data_window <= DATA_WINDOW_RST;
      cfg_r.dte_mode    <= 1'b1;
    end else begin
      if (in_tready) begin
        item_valid_r <= in_tvalid;
      end
      if (res_load) begin
        res_valid_r <= 1'b1;
        st_r        <= st_nxt;
      end else if (out_tready) begin
        res_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_DATA_WINDOW: cfg_r.data_window <= cfg_data[WIN_W-1:0];
          CFG_DTE_MODE:    cfg_r.dte_mode    <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r <= in_item;
    end
    if (res_load) begin
      res_r <= chk_res;
    end
  end

  assign out_tvalid = res_valid_r;
  assign out_tdata  = {7'd0,
                       res_r.reset_origin,
                       res_r.reset_code,
                       res_r.clear_retransmit,
                       res_r.clear_timeout,
                       res_r.send_resume,
                       res_r.release_upto,
                       res_r.release_valid,
                       res_r.restart_reply_timer,
                       res_r.reply_kind,
                       res_r.ps_status};

  a_exp_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, st_r.expected_seq} < WIDE_MOD)
    else $error("expected sequence number outside modulus");

  a_rej_sets_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (res_load && chk_res.reply_kind == REPLY_REJ) |=> st_r.reject_outstanding)
    else $error("reject sent without marking it outstanding");

  a_rr_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
    (res_load && chk_res.reply_kind == REPLY_RR) |=> (st_r.data_count == '0))
    else $error("data count not cleared after rr");

  a_origin_needs_reset: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid_r && res_r.reset_origin) |-> (res_r.reset_code != RST_NONE))
    else $error("reset origin without reset code");

endmodule

>>> rtl/pswc_check.sv
// module: sequence checks of one packet header and next channel state
module pswc_check
  import pswc_pkg::*;
(
  input  pswc_item_t   item,
  input  pswc_state_t  cur,
  input  pswc_cfg_t    cfg,
  output pswc_result_t res,
  output pswc_state_t  nxt
);

  win_pos_t         pr_pos;
  win_pos_t         rej_pos;
  win_pos_t         ps_pos;
  logic [SEQ_W-1:0] ps_inc;
  logic [CNT_W-1:0] cnt_inc;
  logic [WIDE_W-1:0] cnt_sum;
  logic             at_top;
  logic             in_seq;
  logic             dup;
  logic             gap;
  logic             checked;
  logic             want_rr;

  always_comb begin
    pr_pos  = window_pos(item.send_low, item.received_pr, item.send_next);
    rej_pos = window_pos(item.send_low, item.rejected_seq, item.received_pr);
    ps_pos  = window_pos(item.recv_low, item.received_ps, item.recv_high);
    ps_inc  = seq_inc(item.received_ps);
    checked = !(item.is_reset_request && !item.is_data);
    at_top  = (item.received_ps == item.recv_high);
    in_seq  = (item.received_ps == cur.expected_seq) && !at_top;
    dup     = !at_top && (ps_inc == cur.expected_seq);
    gap     = !at_top && ps_pos.hit;
    cnt_inc = (item.is_data && (cur.data_count < CNT_MAX)) ?
              cur.data_count + CNT_W'(1) : cur.data_count;
    cnt_sum = {1'b0, cnt_inc} + {1'b0, item.early_reply_count};
    want_rr = (ps_inc == item.recv_high) ||
              (item.is_data && (cnt_sum >= {1'b0, cfg.data_window}));

    res = '0;
    res.ps_status = PS_UNCHECKED;
    nxt = cur;

    if (checked) begin
      // P(R) against the send window
      if (pr_pos.hit) begin
        if ((pr_pos.to_top == '0) ? (item.send_low != item.send_next)
                                  : (item.send_low != item.received_pr)) begin
          res.release_valid = 1'b1;
          res.release_upto  = item.received_pr;
        end
        if (item.send_timed_out) begin
          res.clear_timeout = 1'b1;
          res.send_resume   = 1'b1;
        end
        if (item.retransmitting && rej_pos.hit) begin
          res.clear_retransmit = 1'b1;
          res.send_resume      = 1'b1;
        end
      end else begin
        res.reset_code = RST_BAD_PR;
      end

      // P(S) against the receive window
      if (in_seq) begin
        res.ps_status          = PS_IN_SEQ;
        nxt.expected_seq       = seq_inc(cur.expected_seq);
        nxt.reject_outstanding = 1'b0;
        nxt.data_count         = cnt_inc;
        if (item.received_ps == item.recv_low) begin
          res.restart_reply_timer = 1'b1;
        end else if (want_rr) begin
          res.reply_kind = REPLY_RR;
        end
      end else if (dup) begin
        res.ps_status = PS_DUPLICATE;
        if (!cur.reject_outstanding) begin
          res.reply_kind = REPLY_RR;
        end
      end else if (gap) begin
        res.ps_status = PS_GAP;
        if (!cur.reject_outstanding) begin
          res.reply_kind         = REPLY_REJ;
          nxt.reject_outstanding = 1'b1;
        end
      end else begin
        res.ps_status = PS_OUT_WIN;
        if (res.reset_code == RST_NONE) begin
          res.reset_code = RST_BAD_PS;
        end
      end

      if (res.reply_kind == REPLY_RR) begin
        nxt.data_count = '0;
      end
      if (res.reset_code != RST_NONE) begin
        res.reset_origin = !cfg.dte_mode;
      end
    end
  end

endmodule

>>> verif/pswc_seq_checker.sv
// checker for the packet sequence window check: predicts each header result and compares it
module pswc_seq_checker
  import pswc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  // ps[3:0] pr[7:4] recv_low[11:8] recv_high[15:12] send_low[19:16] send_next[23:20]
  // send_timed_out[24] retransmitting[25] rejected_seq[29:26] early_reply_count[33:30]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // is_data[0] is_reset_request[1]
  input  logic [IN_USER_W-1:0]  in_tuser,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  // ps_status[2:0] reply_kind[4:3] restart_reply_timer[5] release_valid[6]
  // release_upto[10:7] send_resume[11] clear_timeout[12] clear_retransmit[13]
  // reset_code[15:14] reset_origin[16]
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic [SEQ_W-1:0]      ps_due,
  output int                    pending,
  output int                    errors
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [SEQ_W-1:0] seq_due;
  logic [CNT_W-1:0] data_cnt;
  logic             rej_held;
  logic [WIN_W-1:0] win_limit;
  logic             dte_cause;
  pswc_result_t     pending_results[$];

  assign ps_due = seq_due;

  initial errors = 0;

  // distance from pos to the top of [lo, hi] with wrap, -1 when outside
  function automatic int span_offset(int lo, int pos, int hi);
    if (hi < lo) begin
      if (pos < lo) begin
        pos += SEQ_MODULO;
      end
      hi += SEQ_MODULO;
    end
    return (lo <= pos && pos <= hi) ? hi - pos : -1;
  endfunction

  function automatic logic [SEQ_W-1:0] next_seq(int v);
    return SEQ_W'((v + 1) % SEQ_MODULO);
  endfunction

  function automatic pswc_result_t check_header(pswc_item_t h);
    pswc_result_t r;
    int           ack;
    r = '0;
    r.ps_status  = PS_UNCHECKED;
    r.reply_kind = REPLY_NONE;
    r.reset_code = RST_NONE;
    if (h.is_reset_request && !h.is_data) begin
      return r;
    end
    ack = span_offset(h.send_low, h.received_pr, h.send_next);
    if (ack >= 0) begin
      if ((ack == 0) ? (h.send_low != h.send_next) : (h.send_low != h.received_pr)) begin
        r.release_valid = 1'b1;
        r.release_upto  = h.received_pr;
      end
      if (h.send_timed_out) begin
        r.clear_timeout = 1'b1;
        r.send_resume   = 1'b1;
      end
      if (h.retransmitting && span_offset(h.send_low, h.rejected_seq, h.received_pr) >= 0) begin
        r.clear_retransmit = 1'b1;
        r.send_resume      = 1'b1;
      end
    end else begin
      r.reset_code = RST_BAD_PR;
    end
    if (h.received_ps == seq_due && h.received_ps != h.recv_high) begin
      r.ps_status = PS_IN_SEQ;
      seq_due     = next_seq(seq_due);
      rej_held    = 1'b0;
      if (h.is_data && data_cnt < CNT_MAX) begin
        data_cnt++;
      end
      if (h.received_ps == h.recv_low) begin
        r.restart_reply_timer = 1'b1;
      end else if (next_seq(h.received_ps) == h.recv_high ||
                   (h.is_data &&
                    int'(data_cnt) + int'(h.early_reply_count) >= int'(win_limit))) begin
        r.reply_kind = REPLY_RR;
      end
    end else if (h.received_ps != h.recv_high && next_seq(h.received_ps) == seq_due) begin
      r.ps_status = PS_DUPLICATE;
      if (!rej_held) begin
        r.reply_kind = REPLY_RR;
      end
    end else if (h.received_ps != h.recv_high &&
                 span_offset(h.recv_low, h.received_ps, h.recv_high) >= 0) begin
      r.ps_status = PS_GAP;
      if (!rej_held) begin
        r.reply_kind = REPLY_REJ;
        rej_held     = 1'b1;
      end
    end else begin
      r.ps_status = PS_OUT_WIN;
      if (r.reset_code == RST_NONE) begin
        r.reset_code = RST_BAD_PS;
      end
    end
    if (r.reply_kind == REPLY_RR) begin
      data_cnt = '0;
    end
    if (r.reset_code != RST_NONE) begin
      r.reset_origin = !dte_cause;
    end
    return r;
  endfunction

  function automatic string show(pswc_result_t r);
    return $sformatf({"status %0d reply %0d timer %0b release %0b/%0d resume %0b ",
                      "clr_to %0b clr_rtx %0b reset %0d/%0b"},
                     r.ps_status, r.reply_kind, r.restart_reply_timer, r.release_valid,
                     r.release_upto, r.send_resume, r.clear_timeout, r.clear_retransmit,
                     r.reset_code, r.reset_origin);
  endfunction

  always @(posedge clk) begin
    pswc_item_t   hdr;
    pswc_result_t want;
    pswc_result_t got;
    string        bad;
    if (!rst_n) begin
      seq_due   = '0;
      data_cnt  = '0;
      rej_held  = 1'b0;
      win_limit = DATA_WINDOW_RST;
      dte_cause = 1'b1;
      pending_results.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got.ps_status           = ps_status_t'(out_tdata[2:0]);
        got.reply_kind          = reply_kind_t'(out_tdata[4:3]);
        got.restart_reply_timer = out_tdata[5];
        got.release_valid       = out_tdata[6];
        got.release_upto        = out_tdata[10:7];
        got.send_resume         = out_tdata[11];
        got.clear_timeout       = out_tdata[12];
        got.clear_retransmit    = out_tdata[13];
        got.reset_code          = reset_code_t'(out_tdata[15:14]);
        got.reset_origin        = out_tdata[16];
        if (pending_results.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("result with no header pending: %s", show(got));
          end
        end else begin
          want = pending_results.pop_front();
          bad  = "";
          if (got.ps_status !== want.ps_status) bad = {bad, " ps_status"};
          if (got.reply_kind !== want.reply_kind) bad = {bad, " reply_kind"};
          if (got.restart_reply_timer !== want.restart_reply_timer) bad = {bad, " timer"};
          if (got.release_valid !== want.release_valid) bad = {bad, " release_valid"};
          if (got.release_upto !== want.release_upto) bad = {bad, " release_upto"};
          if (got.send_resume !== want.send_resume) bad = {bad, " send_resume"};
          if (got.clear_timeout !== want.clear_timeout) bad = {bad, " clear_timeout"};
          if (got.clear_retransmit !== want.clear_retransmit) bad = {bad, " clear_retransmit"};
          if (got.reset_code !== want.reset_code) bad = {bad, " reset_code"};
          if (got.reset_origin !== want.reset_origin) bad = {bad, " reset_origin"};
          if (bad != "") begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch at %0t in%s: expected %s, got %s", $realtime, bad,
                       show(want), show(got));
            end
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_DATA_WINDOW) begin
          win_limit = cfg_data[WIN_W-1:0];
        end else if (cfg_index == CFG_DTE_MODE) begin
          dte_cause = cfg_data[0];
        end
      end
      if (in_tvalid && in_tready) begin
        hdr.received_ps       = in_tdata[3:0];
        hdr.received_pr       = in_tdata[7:4];
        hdr.recv_low          = in_tdata[11:8];
        hdr.recv_high         = in_tdata[15:12];
        hdr.send_low          = in_tdata[19:16];
        hdr.send_next         = in_tdata[23:20];
        hdr.send_timed_out    = in_tdata[24];
        hdr.retransmitting    = in_tdata[25];
        hdr.rejected_seq      = in_tdata[29:26];
        hdr.early_reply_count = in_tdata[33:30];
        hdr.is_data           = in_tuser[0];
        hdr.is_reset_request  = in_tuser[1];
        pending_results.push_back(check_header(hdr));
      end
    end
    pending = pending_results.size();
  end

endmodule

>>> verif/packet_seq_window_check_unit_tb.sv
// testbench top: drives packet headers and register writes, checker judges the results
module packet_seq_window_check_unit_tb;
  import pswc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 100000;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [IN_USER_W-1:0]  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic [SEQ_W-1:0]      ps_due;
  int                    pending;
  int                    errors;
  int                    cycle_count = 0;
  logic                  quiet = 1'b0;
  logic                  long_hold_go = 1'b0;

  always #5 clk = ~clk;

  packet_seq_window_check_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  pswc_seq_checker chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ps_due    (ps_due),
    .pending   (pending),
    .errors    (errors)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // receiver: random stall bursts plus one long hold-off
  initial begin
    int  stall_left;
    int  hold_left;
    bit  held_once;
    stall_left = 0;
    hold_left  = 0;
    held_once  = 1'b0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_go && !held_once) begin
        hold_left = 80;
        held_once = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 6) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  function automatic int m8(int v);
    return ((v % SEQ_MODULO) + SEQ_MODULO) % SEQ_MODULO;
  endfunction

  // sequence number k steps from the next expected P(S)
  function automatic int rel_seq(int k);
    return m8(int'(ps_due) + k);
  endfunction

  task automatic push_item(input pswc_item_t it);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_DATA_W'({it.early_reply_count, it.rejected_seq, it.retransmitting,
                             it.send_timed_out, it.send_next, it.send_low, it.recv_high,
                             it.recv_low, it.received_pr, it.received_ps});
    in_tuser  <= {it.is_reset_request, it.is_data};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic send_hdr(input int ps, pr, rl, rh, sl, sn, input bit dat, rst, tmo, rtx,
                          input int rj, er);
    pswc_item_t it;
    it.received_ps       = SEQ_W'(ps);
    it.received_pr       = SEQ_W'(pr);
    it.is_data           = dat;
    it.is_reset_request  = rst;
    it.recv_low          = SEQ_W'(rl);
    it.recv_high         = SEQ_W'(rh);
    it.send_low          = SEQ_W'(sl);
    it.send_next         = SEQ_W'(sn);
    it.send_timed_out    = tmo;
    it.retransmitting    = rtx;
    it.rejected_seq      = SEQ_W'(rj);
    it.early_reply_count = CNT_W'(er);
    push_item(it);
  endtask

  task automatic load_regs(input logic [CFG_DATA_W-1:0] window, input logic dte);
    while (pending != 0) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_DATA_WINDOW;
    cfg_data  <= window;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_index <= CFG_DTE_MODE;
    cfg_data  <= CFG_DATA_W'(dte);
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // mostly well-formed headers around the expected number, the rest raw noise
  task automatic run_phase(input int count);
    pswc_item_t  it;
    logic [63:0] raw;
    int          e;
    int          below;
    int          above;
    int          span;
    for (int i = 0; i < count; i++) begin
      e   = int'(ps_due);
      raw = {$urandom, $urandom};
      it  = raw[$bits(pswc_item_t)-1:0];
      if ($urandom_range(0, 3) != 0) begin
        below = $urandom_range(0, 3);
        above = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 4);
        span  = $urandom_range(0, 5);
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: it.received_ps = SEQ_W'(e);
          6: it.received_ps = SEQ_W'(m8(e - 1));
          7: it.received_ps = SEQ_W'(m8(e + $urandom_range(1, 4)));
          8: it.received_ps = SEQ_W'($urandom_range(0, 7));
          default: ;
        endcase
        it.recv_low  = SEQ_W'(m8(e - below));
        it.recv_high = SEQ_W'(m8(e + above));
        it.send_low  = SEQ_W'($urandom_range(0, 7));
        it.send_next = SEQ_W'(m8(int'(it.send_low) + span));
        if ($urandom_range(0, 9) != 0) begin
          it.received_pr = SEQ_W'(m8(int'(it.send_low) + $urandom_range(0, span)));
        end
        if ($urandom_range(0, 3) != 0) begin
          it.rejected_seq = SEQ_W'(m8(int'(it.send_low) + $urandom_range(0, span)));
        end
        it.send_timed_out = ($urandom_range(0, 3) == 0);
        it.retransmitting = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 7) != 0) begin
          it.early_reply_count = CNT_W'($urandom_range(0, 2));
        end
        it.is_data          = ($urandom_range(0, 7) != 0);
        it.is_reset_request = ($urandom_range(0, 19) == 0);
      end
      push_item(it);
    end
    in_tvalid <= 1'b0;
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_DATA_WINDOW;
    cfg_data  = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // control reset request, no check
    send_hdr(15, 15, 15, 15, 15, 15, 0, 1, 1, 1, 15, 15);
    // empty window restarts the reply timer
    send_hdr(rel_seq(0), 0, rel_seq(0), rel_seq(3), 0, 2, 1, 0, 0, 0, 0, 0);
    // next number is the window top, forces rr
    send_hdr(rel_seq(0), 1, rel_seq(-1), rel_seq(1), 0, 2, 1, 0, 0, 0, 0, 0);
    // data count reaches the window
    send_hdr(rel_seq(0), 2, rel_seq(-1), rel_seq(4), 0, 2, 1, 0, 0, 0, 0, 0);
    send_hdr(rel_seq(0), 2, rel_seq(-1), rel_seq(4), 0, 2, 1, 0, 0, 0, 0, 0);
    // duplicate
    send_hdr(rel_seq(-1), 0, rel_seq(-2), rel_seq(3), 0, 0, 1, 0, 0, 0, 0, 0);
    // gap gives rej once, then nothing while it is outstanding
    send_hdr(rel_seq(2), 3, rel_seq(-1), rel_seq(4), 2, 5, 1, 0, 0, 0, 0, 0);
    send_hdr(rel_seq(1), 3, rel_seq(-1), rel_seq(4), 2, 5, 1, 0, 0, 0, 0, 0);
    send_hdr(rel_seq(-1), 3, rel_seq(-2), rel_seq(4), 2, 5, 1, 0, 0, 0, 0, 0);
    send_hdr(rel_seq(0), 4, rel_seq(-1), rel_seq(4), 2, 5, 1, 0, 0, 0, 0, 0);
    // expected number equal to the window top
    send_hdr(rel_seq(0), 0, rel_seq(-2), rel_seq(0), 0, 0, 1, 0, 0, 0, 0, 0);
    // out of window
    send_hdr(rel_seq(5), 0, rel_seq(0), rel_seq(2), 0, 0, 1, 0, 0, 0, 0, 0);
    // bad p(r), then both numbers bad
    send_hdr(rel_seq(0), 6, rel_seq(-1), rel_seq(3), 0, 3, 1, 0, 0, 0, 0, 0);
    send_hdr(rel_seq(4), 7, rel_seq(0), rel_seq(2), 1, 3, 1, 0, 1, 1, 2, 0);
    // timeout ends, retransmission ends or not
    send_hdr(rel_seq(0), 3, rel_seq(-1), rel_seq(3), 1, 4, 1, 0, 1, 0, 0, 0);
    send_hdr(rel_seq(0), 5, rel_seq(-1), rel_seq(3), 3, 6, 1, 0, 0, 1, 4, 0);
    send_hdr(rel_seq(0), 5, rel_seq(-1), rel_seq(3), 3, 6, 1, 0, 0, 1, 7, 0);
    // wrapped send window
    send_hdr(rel_seq(0), 0, rel_seq(-1), rel_seq(3), 6, 2, 1, 0, 1, 1, 7, 0);
    // numbers beyond the modulo
    send_hdr(15, 12, 9, 14, 10, 13, 1, 0, 0, 1, 15, 15);
    // data packet with the reset bit set is still checked
    send_hdr(rel_seq(0), 0, rel_seq(-1), rel_seq(2), 0, 1, 1, 1, 0, 0, 0, 15);
    // non-data in sequence, then all zeros
    send_hdr(rel_seq(0), 0, rel_seq(-1), rel_seq(3), 0, 0, 0, 0, 0, 0, 0, 0);
    send_hdr(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    in_tvalid <= 1'b0;

    load_regs(4'd1, 1'b0);
    long_hold_go <= 1'b1;
    run_phase(170);
    load_regs(4'd15, 1'b1);
    run_phase(170);
    load_regs(4'd8, 1'b0);
    run_phase(170);
    quiet <= 1'b1;
    load_regs(CFG_DATA_W'($urandom_range(1, 15)), 1'($urandom_range(0, 1)));
    run_phase(170);

    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
